// ----- hw/rtl/tzas_pkg.sv -----
// ----------------------------------------------------------------------------
// tzas_pkg
// Types, codes and reset constants shared by the two-zone alarm supervisor.
// ----------------------------------------------------------------------------
package tzas_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 16;
    localparam int TICKS_W     = 15;

    localparam logic [COUNT_W-1:0] BACKLIGHT_TIMEOUT_RESET = 16'd300;
    localparam logic [TICKS_W-1:0] BUZZER_ON_RESET         = 15'd500;
    localparam logic [TICKS_W-1:0] BUZZER_OFF_RESET        = 15'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BACKLIGHT_TIMEOUT = 2'd0,
        REG_BUZZER_ON_TICKS   = 2'd1,
        REG_BUZZER_OFF_TICKS  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ZONE_HEALTHY = 2'd0,
        ZONE_SHORT   = 2'd1,
        ZONE_FIRE    = 2'd2,
        ZONE_OPEN    = 2'd3
    } zone_status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] backlight_timeout;
        logic [TICKS_W-1:0] buzzer_on_ticks;
        logic [TICKS_W-1:0] buzzer_off_ticks;
    } cfg_t;

    typedef struct packed {
        logic zone1_fire_n;
        logic zone1_open_n;
        logic zone1_short_n;
        logic zone2_fire_n;
        logic zone2_open_n;
        logic zone2_short_n;
        logic battery_low;
        logic silence_req;
        logic lamp_test_n;
        logic evacuate_n;
    } sample_t;

    typedef struct packed {
        logic         hooter_on;
        logic         buzzer_on;
        logic         fire_led_on;
        logic         fault_led_on;
        logic         backlight_on;
        zone_status_t zone1_status;
        zone_status_t zone2_status;
    } result_t;

    function automatic zone_status_t zone_code(input logic fire_n, input logic open_n,
                                               input logic short_n);
        zone_status_t code;
        if (!short_n)
            code = ZONE_SHORT;
        else if (!fire_n)
            code = ZONE_FIRE;
        else if (!open_n)
            code = ZONE_OPEN;
        else
            code = ZONE_HEALTHY;
        return code;
    endfunction

endpackage

// ----- hw/rtl/tzas_if.sv -----
// ----------------------------------------------------------------------------
// tzas_if
// Valid/ready channels for panel samples and supervisor results.
// ----------------------------------------------------------------------------
interface tzas_sample_if;
    logic valid;
    logic ready;
    logic zone1_fire_n;
    logic zone1_open_n;
    logic zone1_short_n;
    logic zone2_fire_n;
    logic zone2_open_n;
    logic zone2_short_n;
    logic battery_low;
    logic silence_req;
    logic lamp_test_n;
    logic evacuate_n;

    modport source (
        output valid, zone1_fire_n, zone1_open_n, zone1_short_n,
               zone2_fire_n, zone2_open_n, zone2_short_n,
               battery_low, silence_req, lamp_test_n, evacuate_n,
        input  ready
    );
    modport sink (
        input  valid, zone1_fire_n, zone1_open_n, zone1_short_n,
               zone2_fire_n, zone2_open_n, zone2_short_n,
               battery_low, silence_req, lamp_test_n, evacuate_n,
        output ready
    );
endinterface

interface tzas_result_if;
    logic       valid;
    logic       ready;
    logic       hooter_on;
    logic       buzzer_on;
    logic       fire_led_on;
    logic       fault_led_on;
    logic       backlight_on;
    logic [1:0] zone1_status;
    logic [1:0] zone2_status;

    modport source (
        output valid, hooter_on, buzzer_on, fire_led_on, fault_led_on,
               backlight_on, zone1_status, zone2_status,
        input  ready
    );
    modport sink (
        input  valid, hooter_on, buzzer_on, fire_led_on, fault_led_on,
               backlight_on, zone1_status, zone2_status,
        output ready
    );
endinterface

// ----- hw/rtl/tzas_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tzas_cfg_regs
// Backlight timeout and buzzer cadence registers behind a plain write port.
// ----------------------------------------------------------------------------
module tzas_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tzas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tzas_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tzas_pkg::cfg_t                   cfg
);
    import tzas_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BACKLIGHT_TIMEOUT: cfg_next.backlight_timeout = cfg_data;
                REG_BUZZER_ON_TICKS:   cfg_next.buzzer_on_ticks   = cfg_data[TICKS_W-1:0];
                REG_BUZZER_OFF_TICKS:  cfg_next.buzzer_off_ticks  = cfg_data[TICKS_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.backlight_timeout <= BACKLIGHT_TIMEOUT_RESET;
            cfg_reg.buzzer_on_ticks   <= BUZZER_ON_RESET;
            cfg_reg.buzzer_off_ticks  <= BUZZER_OFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/tzas_engine.sv -----
// ----------------------------------------------------------------------------
// tzas_engine
// Per-tick supervision: silence latches, cadence and backlight counters, and
// the indicator and zone status logic for one sample.
// ----------------------------------------------------------------------------
module tzas_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tzas_pkg::cfg_t    cfg,
    input  tzas_pkg::sample_t sample,
    output tzas_pkg::result_t result
);
    import tzas_pkg::*;

    logic               zone1_silenced_reg, zone1_silenced_next;
    logic               zone2_silenced_reg, zone2_silenced_next;
    logic               battery_silenced_reg, battery_silenced_next;
    logic [COUNT_W-1:0] cadence_count_reg, cadence_count_next;
    logic [COUNT_W-1:0] backlight_count_reg, backlight_count_next;

    logic               pr1, pr2, fire1, fire2, alarm, normal, cad;
    logic               z1_sil, z2_sil, bat_sil;
    logic [COUNT_W-1:0] cadence_inc, cadence_limit;

    always_comb
    begin
        pr1 = !(sample.zone1_fire_n && sample.zone1_open_n && sample.zone1_short_n);
        pr2 = !(sample.zone2_fire_n && sample.zone2_open_n && sample.zone2_short_n);

        z1_sil  = (pr1 && zone1_silenced_reg) || sample.silence_req;
        z2_sil  = (pr2 && zone2_silenced_reg) || sample.silence_req;
        bat_sil = battery_silenced_reg || sample.silence_req;

        normal = !pr1 && !pr2 && !sample.battery_low && sample.lamp_test_n
                 && sample.evacuate_n;
        alarm  = pr1 || pr2 || sample.battery_low;

        result = '0;
        result.zone1_status = zone_code(sample.zone1_fire_n, sample.zone1_open_n,
                                        sample.zone1_short_n);
        result.zone2_status = zone_code(sample.zone2_fire_n, sample.zone2_open_n,
                                        sample.zone2_short_n);

        // backlight timeout
        backlight_count_next = backlight_count_reg;
        if (normal)
        begin
            if (backlight_count_reg != '0)
            begin
                backlight_count_next = backlight_count_reg - 1'b1;
                result.backlight_on  = 1'b1;
            end
        end
        else
        begin
            backlight_count_next = cfg.backlight_timeout;
            result.backlight_on  = 1'b1;
        end

        // buzzer cadence
        cadence_inc   = cadence_count_reg + 1'b1;
        cadence_limit = {1'b0, cfg.buzzer_on_ticks} + {1'b0, cfg.buzzer_off_ticks};
        fire1 = pr1 && !sample.zone1_fire_n;
        fire2 = pr2 && !sample.zone2_fire_n;
        if (!alarm)
            cadence_count_next = '0;
        else if (cadence_inc > cadence_limit)
            cadence_count_next = '0;
        else
            cadence_count_next = cadence_inc;
        cad = cadence_count_next < {1'b0, cfg.buzzer_on_ticks};

        if (alarm)
        begin
            if (fire1 || fire2)
            begin
                result.fire_led_on = 1'b1;
                if ((fire1 && !z1_sil) || (fire2 && !z2_sil))
                begin
                    result.hooter_on = 1'b1;
                    result.buzzer_on = cad;
                end
            end
            else if ((pr1 && (!sample.zone1_short_n || !sample.zone1_open_n))
                     || (pr2 && (!sample.zone2_short_n || !sample.zone2_open_n)))
            begin
                result.fault_led_on = 1'b1;
                if ((pr1 && !z1_sil) || (pr2 && !z2_sil))
                    result.buzzer_on = cad;
            end
            if (sample.battery_low)
            begin
                result.fault_led_on = 1'b1;
                if (!bat_sil)
                    result.buzzer_on = 1'b1;
            end
        end

        if (!sample.evacuate_n)
        begin
            result.hooter_on   = 1'b1;
            result.buzzer_on   = 1'b1;
            result.fire_led_on = 1'b1;
        end
        if (!sample.lamp_test_n)
        begin
            result.hooter_on    = 1'b1;
            result.buzzer_on    = 1'b1;
            result.fire_led_on  = 1'b1;
            result.fault_led_on = 1'b1;
        end

        zone1_silenced_next   = z1_sil;
        zone2_silenced_next   = z2_sil;
        battery_silenced_next = sample.battery_low && bat_sil;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone1_silenced_reg   <= 1'b0;
            zone2_silenced_reg   <= 1'b0;
            battery_silenced_reg <= 1'b0;
            cadence_count_reg    <= '0;
            backlight_count_reg  <= BACKLIGHT_TIMEOUT_RESET;
        end
        else if (step)
        begin
            zone1_silenced_reg   <= zone1_silenced_next;
            zone2_silenced_reg   <= zone2_silenced_next;
            battery_silenced_reg <= battery_silenced_next;
            cadence_count_reg    <= cadence_count_next;
            backlight_count_reg  <= backlight_count_next;
        end
    end

endmodule

// ----- hw/rtl/two_zone_alarm_supervisor.sv -----
// ----------------------------------------------------------------------------
// two_zone_alarm_supervisor
// Two-zone fire panel supervisor: one panel sample in, one indicator result
// out, with configurable buzzer cadence and backlight timeout.
// ----------------------------------------------------------------------------
// Each sample is one supervision tick. The block takes one sample per clock
// cycle while its results are taken. The sample is captured in an input
// register, evaluated in one pass against the latches and counters, and the
// result is held in a result register until taken. A stalled result register
// holds the pipeline; the input register still takes one more sample while
// the result waits. Configuration writes go straight to the registers and
// should be made while no sample is in flight.
// ----------------------------------------------------------------------------
module two_zone_alarm_supervisor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tzas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tzas_pkg::CFG_DATA_W-1:0]  cfg_data,
    tzas_sample_if.sink                      sample,
    tzas_result_if.source                    result
);
    import tzas_pkg::*;

    cfg_t    cfg;
    sample_t sample_in;
    sample_t s1_item_reg;
    logic    s1_valid_reg, s1_valid_next;
    result_t eval_item;
    result_t out_item_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;

    tzas_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tzas_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg),
        .sample (s1_item_reg),
        .result (eval_item)
    );

    assign sample_in = '{
        zone1_fire_n:  sample.zone1_fire_n,
        zone1_open_n:  sample.zone1_open_n,
        zone1_short_n: sample.zone1_short_n,
        zone2_fire_n:  sample.zone2_fire_n,
        zone2_open_n:  sample.zone2_open_n,
        zone2_short_n: sample.zone2_short_n,
        battery_low:   sample.battery_low,
        silence_req:   sample.silence_req,
        lamp_test_n:   sample.lamp_test_n,
        evacuate_n:    sample.evacuate_n
    };

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next  = (s1_valid_reg && !advance) || sample.valid;
        out_valid_next = (out_valid_reg && !result.ready) || advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            s1_item_reg <= sample_in;
        if (advance)
            out_item_reg <= eval_item;
    end

    assign result.valid        = out_valid_reg;
    assign result.hooter_on    = out_item_reg.hooter_on;
    assign result.buzzer_on    = out_item_reg.buzzer_on;
    assign result.fire_led_on  = out_item_reg.fire_led_on;
    assign result.fault_led_on = out_item_reg.fault_led_on;
    assign result.backlight_on = out_item_reg.backlight_on;
    assign result.zone1_status = out_item_reg.zone1_status;
    assign result.zone2_status = out_item_reg.zone2_status;

endmodule

// ----- tb/tzas_indication_checker.sv -----
// ----------------------------------------------------------------------------
// tzas_indication_checker
// Watches the sample, result and configuration ports of the two-zone alarm
// supervisor. It predicts the indicator item for every accepted panel sample
// and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module tzas_indication_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tzas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tzas_pkg::CFG_DATA_W-1:0]  cfg_data,
    tzas_sample_if                           smp,
    tzas_result_if                           res,
    output int                               mismatches,
    output int                               outstanding
);
    import tzas_pkg::*;

    logic [COUNT_W-1:0] timeout_cfg;
    logic [TICKS_W-1:0] on_cfg;
    logic [TICKS_W-1:0] off_cfg;

    logic               zone1_quiet;
    logic               zone2_quiet;
    logic               battery_quiet;
    logic [COUNT_W-1:0] cadence_ticks;
    logic [COUNT_W-1:0] backlight_left;

    result_t            expected_q[$];
    result_t            want;
    result_t            got;
    sample_t            seen;

    function automatic zone_status_t line_status(input logic fire_n, input logic open_n,
                                                 input logic short_n);
        zone_status_t st;
        st = ZONE_HEALTHY;
        if (!open_n)
            st = ZONE_OPEN;
        if (!fire_n)
            st = ZONE_FIRE;
        if (!short_n)
            st = ZONE_SHORT;
        return st;
    endfunction

    function automatic result_t panel_tick(input sample_t s);
        result_t r;
        logic    pr1;
        logic    pr2;
        logic    fire1;
        logic    fire2;
        logic    cad;
        int      next_cad;
        r   = '0;
        pr1 = !(s.zone1_fire_n && s.zone1_open_n && s.zone1_short_n);
        pr2 = !(s.zone2_fire_n && s.zone2_open_n && s.zone2_short_n);

        if (!pr1)
            zone1_quiet = 1'b0;
        if (!pr2)
            zone2_quiet = 1'b0;
        if (s.silence_req)
        begin
            zone1_quiet   = 1'b1;
            zone2_quiet   = 1'b1;
            battery_quiet = 1'b1;
        end

        if (!pr1 && !pr2 && !s.battery_low && s.lamp_test_n && s.evacuate_n)
        begin
            if (backlight_left != '0)
            begin
                backlight_left = backlight_left - 1'b1;
                r.backlight_on = 1'b1;
            end
        end
        else
        begin
            r.backlight_on = 1'b1;
            backlight_left = timeout_cfg;
        end

        if (!pr1 && !pr2 && !s.battery_low)
            cadence_ticks = '0;
        else
        begin
            next_cad = int'(cadence_ticks) + 1;
            if (next_cad > int'(on_cfg) + int'(off_cfg))
                next_cad = 0;
            cadence_ticks = COUNT_W'(next_cad);
            cad   = int'(cadence_ticks) < int'(on_cfg);
            fire1 = pr1 && !s.zone1_fire_n;
            fire2 = pr2 && !s.zone2_fire_n;
            if (fire1 || fire2)
            begin
                r.fire_led_on = 1'b1;
                if ((fire1 && !zone1_quiet) || (fire2 && !zone2_quiet))
                begin
                    r.hooter_on = 1'b1;
                    r.buzzer_on = cad;
                end
            end
            else if ((pr1 && (!s.zone1_short_n || !s.zone1_open_n)) ||
                     (pr2 && (!s.zone2_short_n || !s.zone2_open_n)))
            begin
                r.fault_led_on = 1'b1;
                if ((pr1 && !zone1_quiet) || (pr2 && !zone2_quiet))
                    r.buzzer_on = cad;
            end
            if (s.battery_low)
            begin
                r.fault_led_on = 1'b1;
                if (!battery_quiet)
                    r.buzzer_on = 1'b1;
            end
        end
        if (!s.battery_low)
            battery_quiet = 1'b0;

        if (!s.evacuate_n)
        begin
            r.hooter_on   = 1'b1;
            r.buzzer_on   = 1'b1;
            r.fire_led_on = 1'b1;
        end
        if (!s.lamp_test_n)
        begin
            r.hooter_on    = 1'b1;
            r.buzzer_on    = 1'b1;
            r.fire_led_on  = 1'b1;
            r.fault_led_on = 1'b1;
        end

        r.zone1_status = line_status(s.zone1_fire_n, s.zone1_open_n, s.zone1_short_n);
        r.zone2_status = line_status(s.zone2_fire_n, s.zone2_open_n, s.zone2_short_n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_cfg    = BACKLIGHT_TIMEOUT_RESET;
            on_cfg         = BUZZER_ON_RESET;
            off_cfg        = BUZZER_OFF_RESET;
            zone1_quiet    = 1'b0;
            zone2_quiet    = 1'b0;
            battery_quiet  = 1'b0;
            cadence_ticks  = '0;
            backlight_left = BACKLIGHT_TIMEOUT_RESET;
            expected_q.delete();
            mismatches     = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BACKLIGHT_TIMEOUT: timeout_cfg = cfg_data;
                    REG_BUZZER_ON_TICKS:   on_cfg      = cfg_data[TICKS_W-1:0];
                    REG_BUZZER_OFF_TICKS:  off_cfg     = cfg_data[TICKS_W-1:0];
                    default:               ;
                endcase
            end

            if (smp.valid && smp.ready)
            begin
                seen.zone1_fire_n  = smp.zone1_fire_n;
                seen.zone1_open_n  = smp.zone1_open_n;
                seen.zone1_short_n = smp.zone1_short_n;
                seen.zone2_fire_n  = smp.zone2_fire_n;
                seen.zone2_open_n  = smp.zone2_open_n;
                seen.zone2_short_n = smp.zone2_short_n;
                seen.battery_low   = smp.battery_low;
                seen.silence_req   = smp.silence_req;
                seen.lamp_test_n   = smp.lamp_test_n;
                seen.evacuate_n    = smp.evacuate_n;
                expected_q.push_back(panel_tick(seen));
            end

            if (res.valid && res.ready)
            begin
                got.hooter_on    = res.hooter_on;
                got.buzzer_on    = res.buzzer_on;
                got.fire_led_on  = res.fire_led_on;
                got.fault_led_on = res.fault_led_on;
                got.backlight_on = res.backlight_on;
                got.zone1_status = zone_status_t'(res.zone1_status);
                got.zone2_status = zone_status_t'(res.zone2_status);
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: got %b", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hooter_on !== want.hooter_on ||
                        got.buzzer_on !== want.buzzer_on ||
                        got.fire_led_on !== want.fire_led_on ||
                        got.fault_led_on !== want.fault_led_on ||
                        got.backlight_on !== want.backlight_on ||
                        got.zone1_status !== want.zone1_status ||
                        got.zone2_status !== want.zone2_status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: hoot/buz/fire/fault/bl/z1/z2 expected %b %b %b %b %b %0d %0d",
                                     want.hooter_on, want.buzzer_on, want.fire_led_on,
                                     want.fault_led_on, want.backlight_on,
                                     want.zone1_status, want.zone2_status);
                            $display("          hoot/buz/fire/fault/bl/z1/z2 got      %b %b %b %b %b %0d %0d",
                                     got.hooter_on, got.buzzer_on, got.fire_led_on,
                                     got.fault_led_on, got.backlight_on,
                                     got.zone1_status, got.zone2_status);
                        end
                    end
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

// ----- tb/two_zone_alarm_supervisor_tb.sv -----
// ----------------------------------------------------------------------------
// two_zone_alarm_supervisor_tb
// Drives panel samples and register settings into the two-zone alarm
// supervisor, with random stalls on both channels, and reports the verdict
// from the mismatch and outstanding counts of the indication checker and an idle watchdog.
// ----------------------------------------------------------------------------
module two_zone_alarm_supervisor_tb;
    import tzas_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_OFF   = 300;

    // zone lines as {fire_n, open_n, short_n}
    localparam logic [2:0] LINES_OK         = 3'b111;
    localparam logic [2:0] LINES_FIRE       = 3'b011;
    localparam logic [2:0] LINES_OPEN       = 3'b101;
    localparam logic [2:0] LINES_SHORT      = 3'b110;
    localparam logic [2:0] LINES_FIRE_SHORT = 3'b010;
    localparam logic [2:0] LINES_FIRE_OPEN  = 3'b001;
    localparam logic [2:0] LINES_OPEN_SHORT = 3'b100;
    localparam logic [2:0] LINES_ALL_LOW    = 3'b000;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   mismatches;
    int   outstanding;
    int   results_taken;
    int   idle_cycles;
    logic sender_calm;

    tzas_sample_if sample_ch ();
    tzas_result_if result_ch ();

    two_zone_alarm_supervisor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    tzas_indication_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .smp         (sample_ch),
        .res         (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles   = 0;
            results_taken = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                results_taken++;
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : result_taker
        int   stall;
        int   stretch;
        logic calm;
        logic held_long;
        result_ch.ready = 1'b0;
        stall     = 0;
        stretch   = 0;
        calm      = 1'b0;
        held_long = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else if (!held_long && results_taken >= 200)
            begin
                held_long       = 1'b1;
                result_ch.ready = 1'b0;
                stall           = HOLD_OFF - 1;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if (stretch == 0)
                begin
                    calm    = ($urandom_range(0, 2) == 0);
                    stretch = $urandom_range(30, 150);
                end
                stretch--;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall = idle_length();
            end
        end
    end

    function automatic sample_t panel(input logic [2:0] z1, input logic [2:0] z2,
                                      input logic bat, input logic sil,
                                      input logic lamp_n, input logic evac_n);
        sample_t s;
        {s.zone1_fire_n, s.zone1_open_n, s.zone1_short_n} = z1;
        {s.zone2_fire_n, s.zone2_open_n, s.zone2_short_n} = z2;
        s.battery_low = bat;
        s.silence_req = sil;
        s.lamp_test_n = lamp_n;
        s.evacuate_n  = evac_n;
        return s;
    endfunction

    function automatic logic [2:0] zone_lines();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return LINES_OK;
        else if (r == 5)
            return LINES_FIRE;
        else if (r == 6)
            return LINES_OPEN;
        else if (r == 7)
            return LINES_SHORT;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic sample_t panel_condition();
        return panel(zone_lines(), zone_lines(), $urandom_range(0, 3) == 0, 1'b0, 1'b1, 1'b1);
    endfunction

    function automatic sample_t noisy_sample(input sample_t base);
        sample_t s;
        int      bit_pos;
        s = base;
        if ($urandom_range(0, 9) == 0)
        begin
            bit_pos    = $urandom_range(0, 9);
            s[bit_pos] = ~s[bit_pos];
        end
        s.silence_req = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 24) == 0)
            s.lamp_test_n = 1'b0;
        if ($urandom_range(0, 24) == 0)
            s.evacuate_n = 1'b0;
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        if (sender_calm || $urandom_range(0, 99) < 55)
            gap = 0;
        else
            gap = idle_length();
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.zone1_fire_n  = s.zone1_fire_n;
        sample_ch.zone1_open_n  = s.zone1_open_n;
        sample_ch.zone1_short_n = s.zone1_short_n;
        sample_ch.zone2_fire_n  = s.zone2_fire_n;
        sample_ch.zone2_open_n  = s.zone2_open_n;
        sample_ch.zone2_short_n = s.zone2_short_n;
        sample_ch.battery_low   = s.battery_low;
        sample_ch.silence_req   = s.silence_req;
        sample_ch.lamp_test_n   = s.lamp_test_n;
        sample_ch.evacuate_n    = s.evacuate_n;
        sample_ch.valid         = 1'b1;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_wr_en = 1'b1;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] timeout,
                                  input logic [CFG_DATA_W-1:0] on_ticks,
                                  input logic [CFG_DATA_W-1:0] off_ticks);
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        write_reg(REG_BACKLIGHT_TIMEOUT, timeout);
        write_reg(REG_BUZZER_ON_TICKS, on_ticks);
        write_reg(REG_BUZZER_OFF_TICKS, off_ticks);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_traffic(input int count);
        sample_t base;
        int      run_len;
        int      sent;
        logic    scrambled;
        sent = 0;
        while (sent < count)
        begin
            base        = panel_condition();
            run_len     = $urandom_range(1, 40);
            scrambled   = ($urandom_range(0, 7) == 0);
            sender_calm = ($urandom_range(0, 3) == 0);
            repeat (run_len)
            begin
                if (sent < count)
                begin
                    if (scrambled)
                        send_sample(sample_t'($urandom_range(0, 1023)));
                    else
                        send_sample(noisy_sample(base));
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] timeout,
                             input logic [CFG_DATA_W-1:0] on_ticks,
                             input logic [CFG_DATA_W-1:0] off_ticks, input int count);
        drain();
        apply_settings(timeout, on_ticks, off_ticks);
        random_traffic(count);
    endtask

    initial
    begin
        cfg_wr_en = 1'b0;
        cfg_index = REG_BACKLIGHT_TIMEOUT;
        cfg_data  = '0;
        sample_ch.valid = 1'b0;
        {sample_ch.zone1_fire_n, sample_ch.zone1_open_n, sample_ch.zone1_short_n} = LINES_OK;
        {sample_ch.zone2_fire_n, sample_ch.zone2_open_n, sample_ch.zone2_short_n} = LINES_OK;
        sample_ch.battery_low = 1'b0;
        sample_ch.silence_req = 1'b0;
        sample_ch.lamp_test_n = 1'b1;
        sample_ch.evacuate_n  = 1'b1;
        sender_calm = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed items under reset settings
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_FIRE, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_FIRE, LINES_OK, 1'b0, 1'b1, 1'b1, 1'b1));
        send_sample(panel(LINES_FIRE, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_FIRE, LINES_FIRE, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_SHORT, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OPEN, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_SHORT, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OPEN, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_FIRE_SHORT, LINES_FIRE_OPEN, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OPEN_SHORT, LINES_ALL_LOW, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b1, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b1, 1'b1, 1'b1, 1'b1));
        send_sample(panel(LINES_FIRE, LINES_OK, 1'b1, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b0));
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(panel(LINES_SHORT, LINES_OK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(sample_t'('0));
        send_sample(sample_t'('1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(panel(LINES_OK, LINES_OK, 1'b0, 1'b0, 1'b1, 1'b1));

        run_phase(16'd5, 16'd3, 16'd4, 111);
        run_phase(16'd0, 16'd0, 16'd6, 111);
        run_phase(16'hFFFF, 16'hFFFF, 16'h7FFF, 111);
        run_phase(16'd2, 16'd1, 16'd0, 111);
        run_phase(16'd1, 16'd7, 16'h8002, 111);
        run_phase(16'd3, 16'd0, 16'd0, 111);
        run_phase(16'($urandom_range(0, 12)), 16'($urandom_range(0, 10)),
                  16'($urandom_range(0, 10)), 111);

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
